// ===== hdl/three_pole_three_zero_compensator_top_assert.svh =====
// Assertion macros for the 3p3z compensator
`ifndef THREE_POLE_THREE_ZERO_COMPENSATOR_TOP_ASSERT_SVH
`define THREE_POLE_THREE_ZERO_COMPENSATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TPZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpz: assertion failed");
`define TPZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpz: assertion failed");
`else
`define TPZ_ASSERT(lbl, prop)
`define TPZ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/tpz_pkg.sv =====
// Types, constants and microcode ROM of the 3p3z compensator
package tpz_pkg;

  localparam int COEF_W = 24;
  localparam int ADC_W  = 12;
  localparam int ERR_W  = 13;
  localparam int DUTY_W = 10;
  localparam int NCOEF  = 7;
  localparam int FRAC_W = 20;
  localparam int UFRAC  = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [NCOEF-1:0][COEF_W-1:0] coef_arr_t;

  typedef enum logic [2:0] {
    T_B0, T_B1, T_B2, T_B3, T_A1, T_A2, T_A3
  } term_e;

  typedef enum logic [1:0] {
    J_NONE, J_ALWAYS, J_NOIN, J_OBUSY
  } jcond_e;

  typedef struct packed {
    logic   take;
    logic   mul_en;
    term_e  term;
    logic   acc_en;
    logic   acc_clr;
    logic   acc_shift;
    logic   fin;
    jcond_e jcond;
    step_t  jtgt;
  } ctrl_t;

  localparam logic [2:0] REG_REF = 3'd7;

  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_MB0  = 4'd1;
  localparam step_t S_MB1  = 4'd2;
  localparam step_t S_MB2  = 4'd3;
  localparam step_t S_MB3  = 4'd4;
  localparam step_t S_MA1  = 4'd5;
  localparam step_t S_MA2  = 4'd6;
  localparam step_t S_MA3  = 4'd7;
  localparam step_t S_ACC  = 4'd8;
  localparam step_t S_HOLD = 4'd9;
  localparam step_t S_FIN  = 4'd10;

  localparam ctrl_t CTRL_NOP = '{
    take: 1'b0, mul_en: 1'b0, term: T_B0, acc_en: 1'b0, acc_clr: 1'b0,
    acc_shift: 1'b0, fin: 1'b0, jcond: J_NONE, jtgt: S_IDLE
  };

  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      S_IDLE: begin
        w.take  = 1'b1;
        w.jcond = J_NOIN;
        w.jtgt  = S_IDLE;
      end
      S_MB0: begin
        w.mul_en = 1'b1;
        w.term   = T_B0;
      end
      S_MB1: begin
        w.mul_en    = 1'b1;
        w.term      = T_B1;
        w.acc_en    = 1'b1;
        w.acc_clr   = 1'b1;
        w.acc_shift = 1'b1;
      end
      S_MB2: begin
        w.mul_en    = 1'b1;
        w.term      = T_B2;
        w.acc_en    = 1'b1;
        w.acc_shift = 1'b1;
      end
      S_MB3: begin
        w.mul_en    = 1'b1;
        w.term      = T_B3;
        w.acc_en    = 1'b1;
        w.acc_shift = 1'b1;
      end
      S_MA1: begin
        w.mul_en    = 1'b1;
        w.term      = T_A1;
        w.acc_en    = 1'b1;
        w.acc_shift = 1'b1;
      end
      S_MA2: begin
        w.mul_en = 1'b1;
        w.term   = T_A2;
        w.acc_en = 1'b1;
      end
      S_MA3: begin
        w.mul_en = 1'b1;
        w.term   = T_A3;
        w.acc_en = 1'b1;
      end
      S_ACC: begin
        w.acc_en = 1'b1;
      end
      S_HOLD: begin
        w.jcond = J_OBUSY;
        w.jtgt  = S_HOLD;
      end
      S_FIN: begin
        w.fin   = 1'b1;
        w.jcond = J_ALWAYS;
        w.jtgt  = S_IDLE;
      end
      default: begin
        w.jcond = J_ALWAYS;
        w.jtgt  = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/tpz_regs.sv =====
// APB configuration registers: coefficients and reference counts
module tpz_regs import tpz_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output coef_arr_t         coef_o,
  output logic [ADC_W-1:0]  ref_o
);

  coef_arr_t        coef_q;
  logic [ADC_W-1:0] ref_q;
  logic [2:0]       idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      ref_q  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_REF: ref_q       <= pwdata[ADC_W-1:0];
        default: coef_q[idx] <= pwdata[COEF_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REF: prdata = {{(DATA_W-ADC_W){1'b0}}, ref_q};
      default: prdata = {{(DATA_W-COEF_W){coef_q[idx][COEF_W-1]}}, coef_q[idx]};
    endcase
  end

  assign coef_o = coef_q;
  assign ref_o  = ref_q;

endmodule

// ===== hdl/tpz_useq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic
module tpz_useq import tpz_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o
);

  `include "three_pole_three_zero_compensator_top_assert.svh"

  step_t pc_q, pc_d;
  ctrl_t ctrl;
  logic  jump;

  assign ctrl = ucode(pc_q);

  always_comb begin
    case (ctrl.jcond)
      J_NONE:   jump = 1'b0;
      J_ALWAYS: jump = 1'b1;
      J_NOIN:   jump = !in_valid_i;
      J_OBUSY:  jump = out_valid_i && !out_ready_i;
      default:  jump = 1'b1;
    endcase
    pc_d = jump ? ctrl.jtgt : pc_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o = ctrl.take;
  assign ctrl_o     = ctrl;

  `TPZ_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, pc_q == S_MB0)
  `TPZ_ASSERT_NEXT(a_hold_stalls, pc_q == S_HOLD && out_valid_i && !out_ready_i,
                   pc_q == S_HOLD)

endmodule

// ===== hdl/tpz_dp.sv =====
// Datapath: error and output histories, shared MAC, round, clamp, result register
module tpz_dp import tpz_pkg::*; #(
  parameter int unsigned DUTY_HIGH = 1023,
  parameter int unsigned DUTY_LOW  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  logic              in_valid_i,
  input  logic [ADC_W-1:0]  adc_sample_i,
  input  coef_arr_t         coef_i,
  input  logic [ADC_W-1:0]  ref_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [DUTY_W-1:0] duty_ticks_o,
  output logic              saturated_o
);

  `include "three_pole_three_zero_compensator_top_assert.svh"

  localparam int unsigned UMAX  = (DUTY_HIGH > DUTY_LOW) ? DUTY_HIGH : DUTY_LOW;
  localparam int UW     = $clog2(UMAX + 1) + UFRAC;
  localparam int OP_W   = (UW + 1 > ERR_W) ? UW + 1 : ERR_W;
  localparam int PROD_W = COEF_W + OP_W;
  localparam int ACC_W  = ((UW > 20) ? UW : 20) + 28;
  localparam int RAW_W  = ACC_W - FRAC_W;
  localparam logic signed [RAW_W-1:0] HI_FIX = RAW_W'(DUTY_HIGH * 256);
  localparam logic signed [RAW_W-1:0] LO_FIX = RAW_W'(DUTY_LOW * 256);
  localparam logic [DUTY_W-1:0] HI_TICKS = DUTY_W'(DUTY_HIGH);
  localparam logic [DUTY_W-1:0] LO_TICKS = DUTY_W'(DUTY_LOW);

  logic signed [ERR_W-1:0]  e0_q;
  logic signed [ERR_W-1:0]  eh_q [3];
  logic        [UW-1:0]     uh_q [3];
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [OP_W-1:0]   op_sel;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, addend, acc_base;
  logic signed [RAW_W-1:0]  raw, clamped;
  logic                     sat;
  logic                     out_valid_q, sat_q;
  logic [DUTY_W-1:0]        duty_q;

  always_comb begin
    case (ctrl_i.term)
      T_B0: begin coef_sel = $signed(coef_i[0]); op_sel = OP_W'(e0_q);    end
      T_B1: begin coef_sel = $signed(coef_i[1]); op_sel = OP_W'(eh_q[0]); end
      T_B2: begin coef_sel = $signed(coef_i[2]); op_sel = OP_W'(eh_q[1]); end
      T_B3: begin coef_sel = $signed(coef_i[3]); op_sel = OP_W'(eh_q[2]); end
      T_A1: begin coef_sel = $signed(coef_i[4]); op_sel = OP_W'($signed({1'b0, uh_q[0]})); end
      T_A2: begin coef_sel = $signed(coef_i[5]); op_sel = OP_W'($signed({1'b0, uh_q[1]})); end
      T_A3: begin coef_sel = $signed(coef_i[6]); op_sel = OP_W'($signed({1'b0, uh_q[2]})); end
      default: begin coef_sel = '0; op_sel = '0; end
    endcase
  end

  // Align error products (Q.20) with output products (Q.28)
  always_comb begin
    addend   = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (ctrl_i.acc_shift) begin
      addend = addend <<< UFRAC;
    end
    acc_base = ctrl_i.acc_clr ? '0 : acc_q;
  end

  // Floor to 8 fractional bits, then upper clamp before lower clamp
  always_comb begin
    raw     = $signed(acc_q[ACC_W-1:FRAC_W]);
    clamped = raw;
    sat     = 1'b0;
    if (raw > HI_FIX) begin
      clamped = HI_FIX;
      sat     = 1'b1;
    end
    if (clamped < LO_FIX) begin
      clamped = LO_FIX;
      sat     = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && in_valid_i) begin
      e0_q <= $signed({1'b0, ref_i}) - $signed({1'b0, adc_sample_i});
    end
    if (ctrl_i.mul_en) begin
      prod_q <= coef_sel * op_sel;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= acc_base + addend;
    end
    if (ctrl_i.fin) begin
      duty_q <= clamped[UFRAC +: DUTY_W];
      sat_q  <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        eh_q[i] <= '0;
        uh_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.fin) begin
        out_valid_q <= 1'b1;
        eh_q[0] <= e0_q;
        eh_q[1] <= eh_q[0];
        eh_q[2] <= eh_q[1];
        uh_q[0] <= clamped[UW-1:0];
        uh_q[1] <= uh_q[0];
        uh_q[2] <= uh_q[1];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign duty_ticks_o = duty_q;
  assign saturated_o  = sat_q;

  `TPZ_ASSERT(a_no_overwrite, ctrl_i.fin |-> !out_valid_q)
  `TPZ_ASSERT(a_valid_from_fin, $rose(out_valid_q) |-> $past(ctrl_i.fin))
  `TPZ_ASSERT(a_sat_at_limit, (out_valid_q && sat_q) |->
              (duty_q == HI_TICKS || duty_q == LO_TICKS))

endmodule

// ===== hdl/three_pole_three_zero_compensator_top.sv =====
// Top level of the 3p3z digital compensator
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+----------------------------
//   input    | in_valid_i / in_ready_o        | adc_sample_i
//   output   | out_valid_o / out_ready_i      | duty_ticks_o, saturated_o
//   config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// An item passes an accept step, seven products on one shared multiplier, each
// registered before it is summed, a final sum step, a hold step, then round,
// clamp and history update, which sets its result valid. A new item is accepted
// only after that update, while the result may still wait; a stalled result
// holds the sequencer in the hold step before the history update.
// Reset clears the histories, config registers, valid flag and sequencer at once.
module three_pole_three_zero_compensator_top import tpz_pkg::*; #(
  parameter int unsigned DUTY_HIGH = 1023,
  parameter int unsigned DUTY_LOW  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADC_W-1:0]  adc_sample_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DUTY_W-1:0] duty_ticks_o,
  output logic              saturated_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  coef_arr_t        coef;
  logic [ADC_W-1:0] ref_counts;
  ctrl_t            ctrl;

  tpz_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef),
    .ref_o   (ref_counts)
  );

  tpz_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  tpz_dp #(
    .DUTY_HIGH (DUTY_HIGH),
    .DUTY_LOW  (DUTY_LOW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_valid_i   (in_valid_i),
    .adc_sample_i (adc_sample_i),
    .coef_i       (coef),
    .ref_i        (ref_counts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .duty_ticks_o (duty_ticks_o),
    .saturated_o  (saturated_o)
  );

endmodule
